>>> hw/rtl/fpb_pkg.sv
// ----------------------------------------------------------------------------
// fpb_pkg
// Shared types and constants for the binary64 power-by-squaring block.
// ----------------------------------------------------------------------------
package fpb_pkg;

  localparam logic [63:0] FP_ONE         = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] FP_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] FP_QUIET_BIT   = 64'h0008_0000_0000_0000;
  localparam logic [10:0] EXP_MAX        = 11'h7FF;
  localparam int          DIV_STEPS      = 58;

  // Operation the datapath asks of the floating-point unit.
  typedef enum logic [1:0] {
    OP_RECIP,
    OP_SQUARE,
    OP_ACCMUL
  } dp_op_t;

  typedef enum logic {
    FOP_MUL,
    FOP_RECIP
  } fpu_op_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_PREP,
    C_RWAIT,
    C_ONECHK,
    C_TEST,
    C_LWAIT,
    C_DONE
  } ctrl_state_t;

  typedef enum logic [3:0] {
    F_IDLE,
    F_MUL,
    F_BNORM,
    F_DIV,
    F_NORM,
    F_DEN,
    F_RND,
    F_FIN
  } fpu_state_t;

  typedef struct packed {
    logic   load;
    logic   op_start;
    dp_op_t op_sel;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic op_done;
    logic mag_zero;
    logic mag_odd;
    logic neg;
    logic base_one;
  } stat_t;

  // Unbiased exponent of a finite operand; subnormals share the minimum.
  function automatic logic signed [12:0] unb_exp(input logic [10:0] f);
    logic signed [12:0] e;
    e = (f == 11'd0) ? 13'sd1 : $signed({2'b00, f});
    return e - 13'sd1023;
  endfunction

endpackage

>>> hw/rtl/fpb_fpu.sv
// ----------------------------------------------------------------------------
// fpb_fpu
// Multi-cycle binary64 multiplier and reciprocal unit, round to nearest even.
// ----------------------------------------------------------------------------
module fpb_fpu
  import fpb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  fpu_op_t     op,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] res
);

  fpu_state_t          state_r, state_nxt;
  logic [5:0]          cnt_r, cnt_nxt;
  logic                sign_r, sign_nxt;
  logic [52:0]         ma_r, ma_nxt, mb_r, mb_nxt;
  logic [105:0]        p_r, p_nxt;
  logic signed [12:0]  x_r, x_nxt;
  logic [53:0]         rem_r, rem_nxt;
  logic [57:0]         q_r, q_nxt;
  logic [63:0]         res_r, res_nxt;

  // Operand classification.
  logic [10:0] fa, fb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
  logic        spec;
  logic [63:0] spec_val;

  // Datapath helpers.
  logic [26:0]        a_part, b_part;
  logic [53:0]        pp;
  logic [105:0]       pp_sh;
  logic               ge;
  logic [53:0]        rs;
  logic signed [12:0] den_amt;
  logic [6:0]         sh;
  logic [105:0]       lost;
  logic [10:0]        expf;
  logic [62:0]        body;
  logic               inc;
  logic signed [12:0] xb;

  assign fa     = a[62:52];
  assign fb     = b[62:52];
  assign a_nan  = (fa == EXP_MAX) && (a[51:0] != 52'd0);
  assign b_nan  = (fb == EXP_MAX) && (b[51:0] != 52'd0);
  assign a_inf  = (fa == EXP_MAX) && (a[51:0] == 52'd0);
  assign b_inf  = (fb == EXP_MAX) && (b[51:0] == 52'd0);
  assign a_zero = (fa == 11'd0) && (a[51:0] == 52'd0);
  assign b_zero = (fb == 11'd0) && (b[51:0] == 52'd0);
  assign sgn    = (op == FOP_MUL) ? (a[63] ^ b[63]) : b[63];

  always_comb begin
    spec     = 1'b0;
    spec_val = 64'd0;
    if (op == FOP_MUL) begin
      if (a_nan) begin
        spec = 1'b1; spec_val = a | FP_QUIET_BIT;
      end else if (b_nan) begin
        spec = 1'b1; spec_val = b | FP_QUIET_BIT;
      end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
        spec = 1'b1; spec_val = FP_DEFAULT_NAN;
      end else if (a_inf || b_inf) begin
        spec = 1'b1; spec_val = {sgn, EXP_MAX, 52'd0};
      end else if (a_zero || b_zero) begin
        spec = 1'b1; spec_val = {sgn, 63'd0};
      end
    end else begin
      if (b_nan) begin
        spec = 1'b1; spec_val = b | FP_QUIET_BIT;
      end else if (b_inf) begin
        spec = 1'b1; spec_val = {sgn, 63'd0};
      end else if (b_zero) begin
        spec = 1'b1; spec_val = {sgn, EXP_MAX, 52'd0};
      end
    end
  end

  // One 27x27 partial product per cycle into the 106-bit accumulator.
  assign a_part = cnt_r[1] ? {1'b0, ma_r[52:27]} : ma_r[26:0];
  assign b_part = cnt_r[0] ? {1'b0, mb_r[52:27]} : mb_r[26:0];
  assign pp     = a_part * b_part;
  always_comb begin
    pp_sh = {52'd0, pp};
    case (cnt_r[1:0])
      2'd1, 2'd2: pp_sh = {25'd0, pp, 27'd0};
      2'd3:       pp_sh = {pp[51:0], 54'd0};
      default:    pp_sh = {52'd0, pp};
    endcase
  end

  // Restoring division step.
  assign ge = rem_r >= {1'b0, mb_r};
  assign rs = ge ? (rem_r - {1'b0, mb_r}) : rem_r;

  assign den_amt = -13'sd1022 - x_r;
  assign sh      = den_amt[6:0];
  assign lost    = p_r & ~({106{1'b1}} << sh);
  assign expf    = p_r[105] ? 11'(x_r + 13'sd1023) : 11'd0;
  assign body    = {expf, p_r[104:53]};
  assign inc     = p_r[52] & ((|p_r[51:0]) | p_r[53]);
  assign xb      = unb_exp(fb);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sign_nxt  = sign_r;
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    p_nxt     = p_r;
    x_nxt     = x_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    res_nxt   = res_r;
    case (state_r)
      F_IDLE: begin
        if (start) begin
          sign_nxt = sgn;
          ma_nxt   = {fa != 11'd0, a[51:0]};
          mb_nxt   = {fb != 11'd0, b[51:0]};
          cnt_nxt  = 6'd0;
          p_nxt    = 106'd0;
          if (spec) begin
            res_nxt   = spec_val;
            state_nxt = F_FIN;
          end else if (op == FOP_MUL) begin
            x_nxt     = unb_exp(fa) + xb + 13'sd1;
            state_nxt = F_MUL;
          end else begin
            x_nxt     = xb;
            state_nxt = F_BNORM;
          end
        end
      end
      F_MUL: begin
        p_nxt   = p_r + pp_sh;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r[1:0] == 2'd3) begin
          state_nxt = F_NORM;
        end
      end
      F_BNORM: begin
        if (mb_r[52]) begin
          rem_nxt   = {2'b01, 52'd0};
          q_nxt     = 58'd0;
          cnt_nxt   = 6'd0;
          state_nxt = F_DIV;
        end else begin
          mb_nxt = {mb_r[51:0], 1'b0};
          x_nxt  = x_r - 13'sd1;
        end
      end
      F_DIV: begin
        q_nxt   = {q_r[56:0], ge};
        rem_nxt = {rs[52:0], 1'b0};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_STEPS - 1)) begin
          p_nxt     = {q_r[56:0], ge, 47'd0, rs != 54'd0};
          x_nxt     = -x_r;
          state_nxt = F_NORM;
        end
      end
      F_NORM: begin
        if (p_r[105]) begin
          state_nxt = F_DEN;
        end else begin
          p_nxt = {p_r[104:0], 1'b0};
          x_nxt = x_r - 13'sd1;
        end
      end
      F_DEN: begin
        if (x_r < -13'sd1022) begin
          if (den_amt >= 13'sd106) begin
            p_nxt = {105'd0, |p_r};
          end else begin
            p_nxt = (p_r >> sh) | {105'd0, |lost};
          end
          x_nxt = -13'sd1022;
        end
        state_nxt = F_RND;
      end
      F_RND: begin
        if (x_r > 13'sd1023) begin
          res_nxt = {sign_r, EXP_MAX, 52'd0};
        end else begin
          res_nxt = {sign_r, body + {62'd0, inc}};
        end
        state_nxt = F_FIN;
      end
      F_FIN: begin
        state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= 6'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    sign_r <= sign_nxt;
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    p_r    <= p_nxt;
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    res_r  <= res_nxt;
  end

  assign done = (state_r == F_FIN);
  assign res  = res_r;

endmodule

>>> hw/rtl/fpb_datapath.sv
// ----------------------------------------------------------------------------
// fpb_datapath
// Base, accumulator and exponent registers around the shared FP unit.
// ----------------------------------------------------------------------------
module fpb_datapath
  import fpb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [63:0] in_base_bits,
  input  logic [31:0] in_exponent,
  output logic [63:0] out_power_bits
);

  logic [63:0] base_r, base_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] mag_r, mag_nxt;
  logic        neg_r, neg_nxt;
  dp_op_t      op_r, op_nxt;
  logic [63:0] out_r, out_nxt;

  logic        fpu_done;
  logic [63:0] fpu_res, fpu_a;
  fpu_op_t     fpu_op;

  assign fpu_op = (cmd.op_sel == OP_RECIP) ? FOP_RECIP : FOP_MUL;
  assign fpu_a  = (cmd.op_sel == OP_ACCMUL) ? acc_r : base_r;

  fpb_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op_start),
    .op    (fpu_op),
    .a     (fpu_a),
    .b     (base_r),
    .done  (fpu_done),
    .res   (fpu_res)
  );

  always_comb begin
    base_nxt = base_r;
    acc_nxt  = acc_r;
    mag_nxt  = mag_r;
    neg_nxt  = neg_r;
    op_nxt   = op_r;
    out_nxt  = out_r;
    if (cmd.load) begin
      base_nxt = in_base_bits;
      acc_nxt  = FP_ONE;
      neg_nxt  = in_exponent[31];
      // The most negative exponent maps to 2^31, which fits unsigned.
      mag_nxt  = in_exponent[31] ? (~in_exponent + 32'd1) : in_exponent;
    end
    if (cmd.op_start) begin
      op_nxt = cmd.op_sel;
    end
    if (fpu_done) begin
      case (op_r)
        OP_RECIP:  base_nxt = fpu_res;
        OP_SQUARE: begin
          base_nxt = fpu_res;
          mag_nxt  = {1'b0, mag_r[31:1]};
        end
        OP_ACCMUL: begin
          acc_nxt = fpu_res;
          mag_nxt = mag_r - 32'd1;
        end
        default: base_nxt = base_r;
      endcase
    end
    if (cmd.out_load) begin
      out_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    acc_r  <= acc_nxt;
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    op_r   <= op_nxt;
    out_r  <= out_nxt;
  end

  assign stat.op_done  = fpu_done;
  assign stat.mag_zero = (mag_r == 32'd0);
  assign stat.mag_odd  = mag_r[0];
  assign stat.neg      = neg_r;
  assign stat.base_one = (base_r == FP_ONE);
  assign out_power_bits = out_r;

endmodule

>>> hw/rtl/fpb_ctrl.sv
// ----------------------------------------------------------------------------
// fpb_ctrl
// Sequencer for reciprocal, squaring loop and result handoff.
// ----------------------------------------------------------------------------
module fpb_ctrl
  import fpb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      C_IDLE:   if (in_valid) state_nxt = C_PREP;
      C_PREP: begin
        if (stat.mag_zero) begin
          state_nxt = C_DONE;
        end else if (stat.neg) begin
          state_nxt = C_RWAIT;
        end else begin
          state_nxt = C_ONECHK;
        end
      end
      C_RWAIT:  if (stat.op_done) state_nxt = C_ONECHK;
      C_ONECHK: state_nxt = stat.base_one ? C_DONE : C_TEST;
      C_TEST:   state_nxt = stat.mag_zero ? C_DONE : C_LWAIT;
      C_LWAIT:  if (stat.op_done) state_nxt = C_TEST;
      C_DONE:   if (slot_free) state_nxt = C_IDLE;
      default:  state_nxt = C_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.op_sel   = OP_SQUARE;
    in_ready     = 1'b0;
    case (state_r)
      C_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      C_PREP: begin
        cmd.op_sel   = OP_RECIP;
        cmd.op_start = !stat.mag_zero && stat.neg;
      end
      C_TEST: begin
        cmd.op_sel   = stat.mag_odd ? OP_ACCMUL : OP_SQUARE;
        cmd.op_start = !stat.mag_zero;
      end
      C_DONE:  cmd.out_load = slot_free;
      default: cmd.load = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= C_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/float_power_by_squaring_top.sv
// ----------------------------------------------------------------------------
// float_power_by_squaring_top
// Binary64 base raised to a signed 32-bit integer power by repeated squaring.
// ----------------------------------------------------------------------------
// One word in gives one word out. A negative exponent first replaces the base
// by its reciprocal, then the block squares the base on even exponents and
// multiplies it into the running result on odd ones, every operation rounded
// to nearest even with full subnormal, infinity and NaN handling. All work
// runs through a single multi-cycle floating-point unit, so the time per word
// is set by the number of operations: a multiply accumulates four 27x27
// partial products and then normalizes and rounds, the reciprocal runs a
// 58-step restoring divider, and subnormal operands add one normalizing shift
// per leading zero. An exponent of magnitude n needs at most about 2*log2(n)
// multiplies; a zero exponent skips all operations and a unit base skips the
// loop. The block takes one word at a time, but the next word is accepted
// while a finished result waits in the output register.
// ----------------------------------------------------------------------------
module float_power_by_squaring_top
  import fpb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_base_bits,
  input  logic signed [31:0] in_exponent,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_power_bits
);

  // Commands flow from the sequencer to the datapath; status flows back.
  cmd_t  cmd;
  stat_t stat;

  fpb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fpb_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_base_bits   (in_base_bits),
    .in_exponent    (in_exponent),
    .out_power_bits (out_power_bits)
  );

  // A word that was just taken keeps the input side closed on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again while a word is in flight");

  // The FP unit only finishes while a word is being worked on.
  a_done_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.op_done |-> !in_ready)
    else $error("FP unit finished with no word in flight");

  // The result register is never overwritten while it still holds a word.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid || out_ready)
    else $error("result register overwritten before it was taken");

  // Operations are started only from a working state.
  a_start_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op_start |-> !in_ready && !cmd.load)
    else $error("FP operation started while idle");

endmodule
